@@ hw/rtl/crp_pkg.sv @@
// crp_pkg: types, result codes and match strings of the certificate response parser
// no dependencies; used by every module of the parser
`default_nettype none

package crp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_start;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  cert_byte;
      logic [15:0] cert_length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic    hit;
      rsp_type rsp;
   } result_type;

   typedef enum logic [2:0] {
      PHASE_IDLE,
      PHASE_HEADER,
      PHASE_DIGITS,
      PHASE_SEPARATOR,
      PHASE_PREFIX,
      PHASE_CERT,
      PHASE_TRAILER,
      PHASE_DONE
   } phase_type;

   localparam logic [2:0] KIND_BYTE      = 3'd0;
   localparam logic [2:0] KIND_OK        = 3'd1;
   localparam logic [2:0] KIND_HEADER    = 3'd2;
   localparam logic [2:0] KIND_SEPARATOR = 3'd3;
   localparam logic [2:0] KIND_PREFIX    = 3'd4;
   localparam logic [2:0] KIND_TRAILER   = 3'd5;
   localparam logic [2:0] KIND_TOO_LARGE = 3'd6;

   localparam logic [15:0] MAX_LEN_RESET = 16'd512;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam int HEAD_LEN = 63;
   localparam int SEP_LEN  = 2;
   localparam int PRE_LEN  = 10;
   localparam int TAIL_LEN = 4;

   localparam logic [HEAD_LEN*8-1:0] HEAD_TEXT =
      "HTTP/1.0 200 OK\r\nContent-Type: application/json\r\n\r\n{\"crt_len\": ";
   localparam logic [SEP_LEN*8-1:0]  SEP_TEXT  = ", ";
   localparam logic [PRE_LEN*8-1:0]  PRE_TEXT  = "\"crt\": \"0x";
   localparam logic [TAIL_LEN*8-1:0] TAIL_TEXT = "\"}\r\n";

   function automatic logic [7:0] head_char(input logic [5:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      if (int'(idx) < HEAD_LEN) begin
         ch = HEAD_TEXT[(HEAD_LEN - 1 - int'(idx)) * 8 +: 8];
      end
      return ch;
   endfunction

   function automatic logic [7:0] sep_char(input logic idx);
      return SEP_TEXT[(SEP_LEN - 1 - int'(idx)) * 8 +: 8];
   endfunction

   function automatic logic [7:0] pre_char(input logic [3:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      if (int'(idx) < PRE_LEN) begin
         ch = PRE_TEXT[(PRE_LEN - 1 - int'(idx)) * 8 +: 8];
      end
      return ch;
   endfunction

   function automatic logic [7:0] tail_char(input logic [1:0] idx);
      return TAIL_TEXT[(TAIL_LEN - 1 - int'(idx)) * 8 +: 8];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/crp_parse_core.sv @@
// crp_parse_core: parser state registers and the per-request match and length logic
// depends on crp_pkg
`default_nettype none

module crp_parse_core #(
   parameter int LENGTH_WIDTH = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire crp_pkg::req_type    item,
   input  wire logic                fire,
   input  wire logic [15:0]         max_len,
   output crp_pkg::result_type      result
);

   localparam int VW = LENGTH_WIDTH + 4;
   localparam int CW = (VW > 16) ? VW : 16;

   crp_pkg::phase_type        phase_ff, phase_in, eff_phase;
   logic [6:0]                pos_ff, pos_in, eff_pos;
   logic [LENGTH_WIDTH-1:0]   acc_ff, acc_in, eff_acc, sat_len;
   logic [15:0]               rem_ff, rem_in, eff_rem, rem_dec, rem_load;
   logic [LENGTH_WIDTH+15:0]  acc_wide, eff_acc_wide;
   logic [7:0]                expect_char;
   logic                      match, is_digit, over_cap, too_big;
   logic [VW-1:0]             value;
   logic [CW-1:0]             value_cmp, max_cmp;

   assign eff_phase = item.message_start ? crp_pkg::PHASE_HEADER : phase_ff;
   assign eff_pos   = item.message_start ? '0 : pos_ff;
   assign eff_acc   = item.message_start ? '0 : acc_ff;
   assign eff_rem   = item.message_start ? '0 : rem_ff;

   assign is_digit = (item.data_byte >= crp_pkg::CHAR_ZERO) &&
                     (item.data_byte <= crp_pkg::CHAR_NINE);
   assign value = (VW'(eff_acc) << 3) + (VW'(eff_acc) << 1) + VW'(item.data_byte[3:0]);
   assign over_cap  = |value[VW-1:LENGTH_WIDTH];
   assign value_cmp = CW'(value);
   assign max_cmp   = CW'(max_len);
   assign too_big   = over_cap || (value_cmp > max_cmp);
   assign sat_len   = over_cap ? '1 : value[LENGTH_WIDTH-1:0];

   assign eff_acc_wide = {16'd0, eff_acc};
   assign rem_load     = eff_acc_wide[15:0];
   assign rem_dec      = (eff_rem != 16'd0) ? eff_rem - 16'd1 : eff_rem;
   assign acc_wide     = {16'd0, acc_in};

   always_comb begin
      case (eff_phase)
         crp_pkg::PHASE_HEADER:    expect_char = crp_pkg::head_char(eff_pos[5:0]);
         crp_pkg::PHASE_DIGITS:    expect_char = crp_pkg::sep_char(1'b0);
         crp_pkg::PHASE_SEPARATOR: expect_char = crp_pkg::sep_char(eff_pos[0]);
         crp_pkg::PHASE_PREFIX:    expect_char = crp_pkg::pre_char(eff_pos[3:0]);
         crp_pkg::PHASE_TRAILER:   expect_char = crp_pkg::tail_char(eff_pos[1:0]);
         default:                  expect_char = 8'h00;
      endcase
   end

   assign match = (item.data_byte == expect_char);

   // next state
   always_comb begin
      phase_in = eff_phase;
      pos_in   = eff_pos;
      acc_in   = eff_acc;
      rem_in   = eff_rem;
      case (eff_phase)
         crp_pkg::PHASE_HEADER: begin
            if (!match) begin
               phase_in = crp_pkg::PHASE_DONE;
            end else if (eff_pos == 7'(crp_pkg::HEAD_LEN - 1)) begin
               phase_in = crp_pkg::PHASE_DIGITS;
               pos_in   = '0;
            end else begin
               pos_in = eff_pos + 7'd1;
            end
         end
         crp_pkg::PHASE_DIGITS: begin
            if (is_digit) begin
               acc_in = too_big ? sat_len : value[LENGTH_WIDTH-1:0];
               if (too_big) begin
                  phase_in = crp_pkg::PHASE_DONE;
               end
            end else if (!match) begin
               phase_in = crp_pkg::PHASE_DONE;
            end else begin
               phase_in = crp_pkg::PHASE_SEPARATOR;
               pos_in   = 7'd1;
            end
         end
         crp_pkg::PHASE_SEPARATOR: begin
            if (!match) begin
               phase_in = crp_pkg::PHASE_DONE;
            end else if (eff_pos == 7'(crp_pkg::SEP_LEN - 1)) begin
               phase_in = crp_pkg::PHASE_PREFIX;
               pos_in   = '0;
            end else begin
               pos_in = eff_pos + 7'd1;
            end
         end
         crp_pkg::PHASE_PREFIX: begin
            if (!match) begin
               phase_in = crp_pkg::PHASE_DONE;
            end else if (eff_pos == 7'(crp_pkg::PRE_LEN - 1)) begin
               rem_in   = rem_load;
               pos_in   = '0;
               phase_in = (rem_load == 16'd0) ? crp_pkg::PHASE_TRAILER : crp_pkg::PHASE_CERT;
            end else begin
               pos_in = eff_pos + 7'd1;
            end
         end
         crp_pkg::PHASE_CERT: begin
            rem_in = rem_dec;
            if (rem_dec == 16'd0) begin
               phase_in = crp_pkg::PHASE_TRAILER;
               pos_in   = '0;
            end
         end
         crp_pkg::PHASE_TRAILER: begin
            if (!match || (eff_pos == 7'(crp_pkg::TAIL_LEN - 1))) begin
               phase_in = crp_pkg::PHASE_DONE;
            end else begin
               pos_in = eff_pos + 7'd1;
            end
         end
         default: begin
            phase_in = eff_phase;
         end
      endcase
   end

   // result
   always_comb begin
      result                 = '0;
      result.rsp.cert_length = acc_wide[15:0];
      case (eff_phase)
         crp_pkg::PHASE_HEADER: begin
            result.hit      = !match;
            result.rsp.kind = crp_pkg::KIND_HEADER;
            result.rsp.last = 1'b1;
         end
         crp_pkg::PHASE_DIGITS: begin
            result.hit      = is_digit ? too_big : !match;
            result.rsp.kind = is_digit ? crp_pkg::KIND_TOO_LARGE : crp_pkg::KIND_SEPARATOR;
            result.rsp.last = 1'b1;
         end
         crp_pkg::PHASE_SEPARATOR: begin
            result.hit      = !match;
            result.rsp.kind = crp_pkg::KIND_SEPARATOR;
            result.rsp.last = 1'b1;
         end
         crp_pkg::PHASE_PREFIX: begin
            result.hit      = !match;
            result.rsp.kind = crp_pkg::KIND_PREFIX;
            result.rsp.last = 1'b1;
         end
         crp_pkg::PHASE_CERT: begin
            result.hit           = 1'b1;
            result.rsp.kind      = crp_pkg::KIND_BYTE;
            result.rsp.cert_byte = item.data_byte;
         end
         crp_pkg::PHASE_TRAILER: begin
            result.hit      = !match || (eff_pos == 7'(crp_pkg::TAIL_LEN - 1));
            result.rsp.kind = match ? crp_pkg::KIND_OK : crp_pkg::KIND_TRAILER;
            result.rsp.last = 1'b1;
         end
         default: begin
            result.hit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= crp_pkg::PHASE_IDLE;
         pos_ff   <= '0;
         acc_ff   <= '0;
         rem_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/crp_rsp_reg.sv @@
// crp_rsp_reg: result register holding one response until the consumer takes it
// depends on crp_pkg
`default_nettype none

module crp_rsp_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire crp_pkg::rsp_type load_data,
   input  wire logic             rsp_stall,
   output logic                  rsp_valid,
   output crp_pkg::rsp_type      rsp_data,
   output logic                  free
);

   logic             valid_ff, valid_in;
   crp_pkg::rsp_type data_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/cert_response_parser_unit.sv @@
// certificate response parser: one request byte per cycle unless a full, stalled result
// register holds back a result; each accepted request is held in the input register and
// any result it yields, from the single-pass match and length update, goes into the
// result register; synchronous active-high reset clears the parser to idle, empties
// both registers and sets the maximum certificate length to 512
// depends on crp_pkg, crp_parse_core, crp_rsp_reg
`default_nettype none

module cert_response_parser_unit #(
   parameter int LENGTH_WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire crp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output crp_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [15:0]      csr_data
);

   logic                in_valid_ff, in_valid_in;
   crp_pkg::req_type    in_data_ff;
   logic [15:0]         max_len_ff, max_len_in;
   crp_pkg::result_type result;
   logic                out_free, advance, out_load;

   assign csr_ready  = 1'b1;
   assign max_len_in = (csr_valid && csr_ready) ? csr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= crp_pkg::MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign advance     = in_valid_ff && (!result.hit || out_free);
   assign out_load    = advance && result.hit;
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
   end

   crp_parse_core #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .item    (in_data_ff),
      .fire    (advance),
      .max_len (max_len_ff),
      .result  (result)
   );

   crp_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (result.rsp),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .free      (out_free)
   );

   // back-pressure only comes from a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall))
      else $error("request stalled without a full result register");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid && (rsp_data == $past(result.rsp))))
      else $error("loaded result not presented");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !out_load) |=> !rsp_valid)
      else $error("taken result presented again");

   a_byte_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_load && (result.rsp.kind == crp_pkg::KIND_BYTE)) |-> !result.rsp.last)
      else $error("certificate byte marked as end of parse");

endmodule

`default_nettype wire
